/* src/shqp_pkg.sv */
// Shared types and constants for the quadratic-probe hash insert unit.
package shqp_pkg;

  localparam int KEY_W  = 64;
  localparam int LEN_W  = 4;
  localparam int SIZE_W = 11;
  localparam int IDX_W  = 10;
  localparam int NUM_W  = 15;
  localparam int DIV_STEPS = NUM_W;
  localparam logic [7:0] CHAR_BASE = 8'h41;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [KEY_W-1:0] key_chars;
    logic [LEN_W-1:0] key_length;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic             failed;
  } out_word_t;

  typedef enum logic [1:0] {
    SEL_HOME,
    SEL_FWD,
    SEL_BWD
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_HOME,
    ST_CMP_HOME,
    ST_RD_FWD,
    ST_CMP_FWD,
    ST_RD_BWD,
    ST_CMP_BWD
  } state_t;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      div_step;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      probe_init;
    logic      probe_adv;
    logic      write_hit;
    logic      report_fail;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic usable;
    logic half_zero;
    logic probe_last;
  } ctl_stat_t;

endpackage

/* src/shqp_ctrl.sv */
// Sequencer for clear pass, hash modulo and probe loop.
module shqp_ctrl import shqp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel = SEL_HOME;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_RD_HOME;
      end
      ST_RD_HOME: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = SEL_HOME;
        state_next   = ST_CMP_HOME;
      end
      ST_CMP_HOME: begin
        if (stat.usable) begin
          cmd.write_hit = 1'b1;
          state_next    = ST_IDLE;
        end else if (stat.half_zero) begin
          cmd.report_fail = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.probe_init = 1'b1;
          state_next     = ST_RD_FWD;
        end
      end
      ST_RD_FWD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = SEL_FWD;
        state_next   = ST_CMP_FWD;
      end
      ST_CMP_FWD: begin
        if (stat.usable) begin
          cmd.write_hit = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_RD_BWD;
        end
      end
      ST_RD_BWD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = SEL_BWD;
        state_next   = ST_CMP_BWD;
      end
      ST_CMP_BWD: begin
        if (stat.usable) begin
          cmd.write_hit = 1'b1;
          state_next    = ST_IDLE;
        end else if (stat.probe_last) begin
          cmd.report_fail = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = ST_RD_FWD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* src/shqp_dp.sv */
// Datapath: key capture, hash divider, probe arithmetic and slot memory.
module shqp_dp import shqp_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_CHARS   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  in_word_t          in_word,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] cfg_data,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  output logic              done,
  output out_word_t         out_word
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_CHARS);

  // configuration register
  logic [SIZE_W-1:0] table_size;
  always_ff @(posedge clk) begin
    if (rst)            table_size <= SIZE_RESET;
    else if (cfg_valid) table_size <= cfg_data;
  end

  // effective size: zero acts as one, clamp to depth
  logic [SIZE_W-1:0] size_eff;
  always_comb begin
    if (table_size == '0)                      size_eff = SIZE_W'(1);
    else if ({6'd0, table_size} > DEPTH17)      size_eff = DEPTH17[SIZE_W-1:0];
    else                                        size_eff = table_size;
  end

  // key masking and hash digits
  logic [LEN_W-1:0] len_c;
  logic [KEY_W-1:0] key_m;
  logic [NUM_W-1:0] num_c;
  logic [7:0]       ch;
  logic [2:0]       bsel;
  always_comb begin
    len_c = (in_word.key_length > MAX_LEN) ? MAX_LEN : in_word.key_length;
    for (int b = 0; b < 8; b++) begin
      key_m[8*b +: 8] = (LEN_W'(b) < len_c) ? in_word.key_chars[8*b +: 8] : 8'd0;
    end
    num_c = '0;
    for (int d = 0; d < 3; d++) begin
      bsel = 3'(len_c - LEN_W'(1) - LEN_W'(d));
      ch   = key_m[8*bsel +: 8];
      if (LEN_W'(d) < len_c) num_c[5*d +: 5] = 5'(ch - CHAR_BASE);
    end
  end

  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  len;
  logic [SIZE_W-1:0] size;
  logic [NUM_W-1:0]  num;
  logic [3:0]        div_cnt;
  logic [SIZE_W-1:0] home;
  logic [SIZE_W:0]   rem_sh;

  // restoring divider, one numerator bit per cycle; remainder is home slot
  assign rem_sh = {home, num[NUM_W-1]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= key_m;
      len     <= len_c;
      size    <= size_eff;
      num     <= num_c;
      home    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      num     <= {num[NUM_W-2:0], 1'b0};
      div_cnt <= div_cnt + 4'd1;
      if (rem_sh >= {1'b0, size}) home <= SIZE_W'(rem_sh - {1'b0, size});
      else                        home <= rem_sh[SIZE_W-1:0];
    end
  end
  assign stat.div_last = (div_cnt == 4'(DIV_STEPS - 1));

  // probe offsets: sq = i*i mod size, inc = (2i+1) mod size
  logic [SIZE_W-1:0] half, pi, sq, inc, inc_init;
  logic [SIZE_W:0]   sq_sum, inc_sum, fwd_sum;
  logic [SIZE_W-1:0] sq_n, inc_n, fwd, bwd;
  assign half     = size >> 1;
  assign inc_init = (size <= SIZE_W'(3)) ? SIZE_W'(3) - size : SIZE_W'(3);
  assign sq_sum   = {1'b0, sq} + {1'b0, inc};
  assign sq_n     = (sq_sum >= {1'b0, size}) ? SIZE_W'(sq_sum - {1'b0, size})
                                             : sq_sum[SIZE_W-1:0];
  assign inc_sum  = {1'b0, inc} + (SIZE_W+1)'(2);
  assign inc_n    = (inc_sum >= {1'b0, size}) ? SIZE_W'(inc_sum - {1'b0, size})
                                              : inc_sum[SIZE_W-1:0];
  assign fwd_sum  = {1'b0, home} + {1'b0, sq};
  assign fwd      = (fwd_sum >= {1'b0, size}) ? SIZE_W'(fwd_sum - {1'b0, size})
                                              : fwd_sum[SIZE_W-1:0];
  assign bwd      = (home >= sq) ? home - sq : home + size - sq;

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pi  <= SIZE_W'(1);
      sq  <= SIZE_W'(1);
      inc <= inc_init;
    end else if (cmd.probe_adv) begin
      pi  <= pi + SIZE_W'(1);
      sq  <= sq_n;
      inc <= inc_n;
    end
  end
  assign stat.half_zero  = (half == '0);
  assign stat.probe_last = (pi == half);

  // probe address select
  logic [SIZE_W-1:0]    slot_sel, slot;
  logic [AW+SIZE_W-1:0] slot_wide, sel_wide;
  always_comb begin
    case (cmd.addr_sel)
      SEL_HOME: slot_sel = home;
      SEL_FWD:  slot_sel = fwd;
      SEL_BWD:  slot_sel = bwd;
      default:  slot_sel = home;
    endcase
  end
  assign sel_wide  = (AW+SIZE_W)'(slot_sel);
  assign slot_wide = (AW+SIZE_W)'(slot);

  // slot memory: {length, key}, cleared by a sweep after reset
  logic [LEN_W+KEY_W-1:0] mem [TABLE_DEPTH];
  logic [LEN_W+KEY_W-1:0] rdata;
  logic [AW-1:0]          clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
  end
  assign stat.clr_last = (clr_cnt == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.clr_step)       mem[clr_cnt] <= '0;
    else if (cmd.write_hit) mem[slot_wide[AW-1:0]] <= {len, key};
    if (cmd.rd_en) begin
      rdata <= mem[sel_wide[AW-1:0]];
      slot  <= slot_sel;
    end
  end

  // hit test: empty slot or same key
  logic [LEN_W-1:0] r_len;
  logic [KEY_W-1:0] r_key;
  assign r_len = rdata[LEN_W+KEY_W-1:KEY_W];
  assign r_key = rdata[KEY_W-1:0];
  assign stat.usable = (r_len == '0) || ((r_len == len) && (r_key == key));

  // result word
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.write_hit | cmd.report_fail;
  end
  always_ff @(posedge clk) begin
    if (cmd.write_hit) begin
      out_word.slot_index <= slot[IDX_W-1:0];
      out_word.failed     <= 1'b0;
    end else if (cmd.report_fail) begin
      out_word.slot_index <= '0;
      out_word.failed     <= 1'b1;
    end
  end

endmodule

/* src/string_hash_quadratic_probe_insert_unit.sv */
// Top level of the string-key hash insert unit with quadratic probing.
//
//  channel   signals                    direction  transfer
//  command   start, busy, in_word       in         start & !busy
//  result    done, out_word             out        done, one cycle, no stall
//  config    cfg_valid, cfg_ready,      in         cfg_valid & cfg_ready
//            cfg_data
//
// A word passes through the hash modulo (15-step bit-serial divider), then
// through memory probes on the single read port, each a read state and a
// compare state, until a usable slot is found or probing runs out.
// After reset a clearing pass over all TABLE_DEPTH slots runs with busy high.
// The result strobe leaves no way to stall; a new word may start in the
// cycle done is shown.
module string_hash_quadratic_probe_insert_unit import shqp_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_CHARS   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              done,
  output out_word_t         out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  shqp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  shqp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_CHARS   (KEY_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .out_word  (out_word)
  );

endmodule
